// ----- src/lef_pkg.sv -----
package lef_pkg;

  // Default build limits
  localparam int MAX_WIDTH_DEF      = 4096;
  localparam int MAX_COMPONENTS_DEF = 4;

  // Fixed limits and field widths
  localparam int MAX_HEIGHT  = 4096;
  localparam int MIN_DIM     = 3;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int COMP_CFG_W  = 3;
  localparam int SMP_W       = 8;
  localparam int ROW_W       = 13;
  localparam int COMP_IDX_W  = 2;
  localparam int PIX_MAX     = 255;

  // Register reset values
  localparam int WIDTH_RST   = 640;
  localparam int HEIGHT_RST  = 480;
  localparam int COMPS_RST   = 3;

  // Front/back queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_COMPS  = 2'd2
  } cfg_reg_t;

  // One classified request, as handed from front to back
  typedef struct packed {
    logic                  is_pix;
    logic                  emit;
    logic                  border;
    logic                  last;
    logic [COMP_IDX_W-1:0] comp;
    logic [SMP_W-1:0]      top;
    logic [SMP_W-1:0]      mid;
    logic [SMP_W-1:0]      smp;
  } qent_t;

  typedef struct packed {
    logic [QCW-1:0] count;
    logic           empty;
  } qstat_t;

endpackage

// ----- src/lef_in_if.sv -----
interface lef_in_if;
  import lef_pkg::*;

  logic             valid;
  logic             ready;
  logic             cmd;
  logic [SMP_W-1:0] sample;
  logic             frame_start;

  modport source(output valid, cmd, sample, frame_start, input ready);
  modport sink(input valid, cmd, sample, frame_start, output ready);
endinterface

// ----- src/lef_out_if.sv -----
interface lef_out_if;
  import lef_pkg::*;

  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] filtered;
  logic             frame_last;

  modport source(output valid, filtered, frame_last, input ready);
  modport sink(input valid, filtered, frame_last, output ready);
endinterface

// ----- src/lef_front.sv -----
module lef_front #(
  parameter int MAX_WIDTH      = lef_pkg::MAX_WIDTH_DEF,
  parameter int MAX_COMPONENTS = lef_pkg::MAX_COMPONENTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lef_in_if.sink                       in_ch,
  input  logic                         cfg_we,
  input  logic [lef_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lef_pkg::CFG_W-1:0]    cfg_data,
  input  lef_pkg::qstat_t              q_stat,
  output logic                         q_push,
  output lef_pkg::qent_t               q_ent
);
  import lef_pkg::*;

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CLW   = $clog2(MAX_WIDTH);
  localparam int CW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int DEPTH = MAX_WIDTH * MAX_COMPONENTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = WW + COMP_CFG_W;

  // Configuration
  logic [CFG_W-1:0]      width_r, width_nxt;
  logic [CFG_W-1:0]      height_r, height_nxt;
  logic [COMP_CFG_W-1:0] comps_r, comps_nxt;
  logic                  cfg_hit;

  logic [WW-1:0]         w_eff;
  logic [ROW_W-1:0]      h_eff;
  logic [COMP_CFG_W-1:0] nc_eff;
  logic [DW-1:0]         drain;

  // Input position
  logic [CLW-1:0]   col_r, col_nxt, col_c;
  logic [ROW_W-1:0] row_r, row_nxt, row_c;
  logic [CW-1:0]    ci_r, ci_nxt, ci_c;
  logic [AW-1:0]    addr_r, addr_nxt, addr_c;
  logic [DW-1:0]    fl_r, fl_nxt, fl_c;

  logic accept, fs, pix_live, fl_live, rd_en, last_comp, last_col;

  // Memory read stage
  logic          m_valid_r, m_valid_nxt;
  qent_t         m_ent_r, m_ent_nxt;
  logic [AW-1:0] m_addr_r;

  logic [SMP_W-1:0] upper_mem [DEPTH];
  logic [SMP_W-1:0] middle_mem [DEPTH];
  logic [SMP_W-1:0] top_rd_r, mid_rd_r;

  always_comb begin
    if (width_r < CFG_W'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r < CFG_W'(MIN_DIM)) begin
      h_eff = ROW_W'(MIN_DIM);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(height_r);
    end
    if (comps_r == '0) begin
      nc_eff = COMP_CFG_W'(1);
    end else if (32'(comps_r) > 32'(MAX_COMPONENTS)) begin
      nc_eff = COMP_CFG_W'(MAX_COMPONENTS);
    end else begin
      nc_eff = comps_r;
    end
    // outputs still pending once the last sample is in
    drain = DW'((DW'(w_eff) + DW'(1)) * DW'(nc_eff));
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    comps_nxt  = comps_r;
    cfg_hit    = 1'b0;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_WIDTH: begin
          width_nxt = cfg_data;
          cfg_hit   = 1'b1;
        end
        REG_HEIGHT: begin
          height_nxt = cfg_data;
          cfg_hit    = 1'b1;
        end
        REG_COMPS: begin
          comps_nxt = cfg_data[COMP_CFG_W-1:0];
          cfg_hit   = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  assign in_ch.ready = (q_stat.count + QCW'(m_valid_r)) < QCW'(QDEPTH);
  assign accept      = in_ch.valid && in_ch.ready;
  assign fs          = !in_ch.cmd && in_ch.frame_start;

  always_comb begin
    col_c  = fs ? '0 : col_r;
    row_c  = fs ? '0 : row_r;
    ci_c   = fs ? '0 : ci_r;
    addr_c = fs ? '0 : addr_r;
    fl_c   = fs ? '0 : fl_r;

    pix_live  = !in_ch.cmd && (row_c < h_eff);
    fl_live   = in_ch.cmd && (row_r >= h_eff) && (fl_r < drain);
    rd_en     = accept && pix_live;
    last_comp = (COMP_CFG_W'(ci_c) + COMP_CFG_W'(1)) >= nc_eff;
    last_col  = (WW'(col_c) + WW'(1)) >= w_eff;

    col_nxt  = col_r;
    row_nxt  = row_r;
    ci_nxt   = ci_r;
    addr_nxt = addr_r;
    fl_nxt   = fl_r;

    if (accept && !in_ch.cmd) begin
      col_nxt  = col_c;
      row_nxt  = row_c;
      ci_nxt   = ci_c;
      addr_nxt = addr_c;
      fl_nxt   = fl_c;
      if (pix_live) begin
        if (last_comp) begin
          ci_nxt = '0;
          if (last_col) begin
            col_nxt  = '0;
            row_nxt  = row_c + ROW_W'(1);
            addr_nxt = '0;
          end else begin
            col_nxt  = col_c + CLW'(1);
            addr_nxt = addr_c + AW'(1);
          end
        end else begin
          ci_nxt   = ci_c + CW'(1);
          addr_nxt = addr_c + AW'(1);
        end
      end
    end
    if (accept && fl_live) begin
      fl_nxt = fl_r + DW'(1);
    end
    // a register write restarts the frame
    if (cfg_hit) begin
      col_nxt  = '0;
      row_nxt  = '0;
      ci_nxt   = '0;
      addr_nxt = '0;
      fl_nxt   = '0;
    end

    m_valid_nxt    = accept && (pix_live || fl_live);
    m_ent_nxt      = '0;
    m_ent_nxt.comp = COMP_IDX_W'(ci_c);
    m_ent_nxt.smp  = in_ch.sample;
    if (pix_live) begin
      m_ent_nxt.is_pix = 1'b1;
      m_ent_nxt.emit   = (row_c >= ROW_W'(2)) || (row_c == ROW_W'(1) && col_c != '0);
      m_ent_nxt.border = (col_c <= CLW'(1)) || (row_c == ROW_W'(1));
    end else begin
      m_ent_nxt.emit   = 1'b1;
      m_ent_nxt.border = 1'b1;
      m_ent_nxt.last   = (fl_r + DW'(1)) == drain;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= CFG_W'(WIDTH_RST);
      height_r  <= CFG_W'(HEIGHT_RST);
      comps_r   <= COMP_CFG_W'(COMPS_RST);
      col_r     <= '0;
      row_r     <= '0;
      ci_r      <= '0;
      addr_r    <= '0;
      fl_r      <= '0;
      m_valid_r <= 1'b0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      comps_r   <= comps_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      ci_r      <= ci_nxt;
      addr_r    <= addr_nxt;
      fl_r      <= fl_nxt;
      m_valid_r <= m_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_ent_r  <= m_ent_nxt;
      m_addr_r <= addr_c;
    end
  end

  // Read both rows, replace middle with the new sample (read first)
  always_ff @(posedge clk) begin
    if (rd_en) begin
      top_rd_r            <= upper_mem[addr_c];
      mid_rd_r            <= middle_mem[addr_c];
      middle_mem[addr_c]  <= in_ch.sample;
    end
  end

  // Promote the old middle row to the upper row in the cycle after the read
  always_ff @(posedge clk) begin
    if (m_valid_r && m_ent_r.is_pix) begin
      upper_mem[m_addr_r] <= mid_rd_r;
    end
  end

  assign q_push = m_valid_r;

  always_comb begin
    q_ent     = m_ent_r;
    q_ent.top = top_rd_r;
    q_ent.mid = mid_rd_r;
  end

endmodule

// ----- src/lef_queue.sv -----
module lef_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_push,
  input  lef_pkg::qent_t  q_ent,
  input  logic            q_pop,
  output lef_pkg::qent_t  q_head,
  output lef_pkg::qstat_t q_stat
);
  import lef_pkg::*;

  qent_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = q_push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r + QCW'(q_push) - QCW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_ent;
    end
  end

  assign q_head       = mem_r[rd_ptr_r];
  assign q_stat.count = count_r;
  assign q_stat.empty = (count_r == '0);

endmodule

// ----- src/lef_back.sv -----
module lef_back #(
  parameter int MAX_COMPONENTS = lef_pkg::MAX_COMPONENTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lef_pkg::qstat_t q_stat,
  input  lef_pkg::qent_t  q_head,
  output logic            q_pop,
  lef_out_if.source       out_ch
);
  import lef_pkg::*;

  localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int SW = SMP_W + 3;

  logic [SMP_W-1:0] win_r [MAX_COMPONENTS][3][3];
  logic [CW-1:0]    comp;
  logic [SW-1:0]    center_x8, nsum;
  logic signed [SW:0] diff;
  logic [SMP_W-1:0] resp;

  logic             out_valid_r, out_valid_nxt;
  logic [SMP_W-1:0] filtered_r;
  logic             last_r;

  assign comp  = q_head.comp[CW-1:0];
  assign q_pop = !q_stat.empty && (!out_valid_r || out_ch.ready);

  // Response on the window as it stands after this column shifts in
  always_comb begin
    center_x8 = {win_r[comp][1][2], 3'b000};
    nsum = SW'(win_r[comp][0][1]) + SW'(win_r[comp][0][2]) + SW'(q_head.top)
         + SW'(win_r[comp][1][1]) + SW'(q_head.mid)
         + SW'(win_r[comp][2][1]) + SW'(win_r[comp][2][2]) + SW'(q_head.smp);
    diff = $signed({1'b0, center_x8}) - $signed({1'b0, nsum});
    if (!q_head.is_pix || q_head.border || diff < 0) begin
      resp = '0;
    end else if (diff > (SW + 1)'(PIX_MAX)) begin
      resp = SMP_W'(PIX_MAX);
    end else begin
      resp = diff[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.is_pix) begin
      for (int r = 0; r < 3; r++) begin
        win_r[comp][r][0] <= win_r[comp][r][1];
        win_r[comp][r][1] <= win_r[comp][r][2];
      end
      win_r[comp][0][2] <= q_head.top;
      win_r[comp][1][2] <= q_head.mid;
      win_r[comp][2][2] <= q_head.smp;
    end
  end

  always_comb begin
    if (q_pop) begin
      out_valid_nxt = q_head.emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      filtered_r <= resp;
      last_r     <= q_head.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.filtered   = filtered_r;
  assign out_ch.frame_last = last_r;

endmodule

// ----- src/laplacian_edge_filter_3x3.sv -----
// 3x3 Laplacian edge filter for a raster stream of interleaved 8-bit samples.
// Each component is filtered on its own (eight times the center minus the
// eight neighbors, clamped to 0..255); pixels on the outer one-pixel border
// give 0. The block takes one request per clock and keeps that rate as long
// as the result side takes one result per clock. The rate is set by the
// line stores: each sample needs one read of both line rows and one write
// back, on separate ports, so every memory sees one read and one write per
// cycle. When a sample is accepted the line-store read registers; the queue
// then takes the request, and the output register loads from the queue head
// once out_ch can take a result, so results wait in the queue while out_ch
// stalls. A result trails its sample by one row plus one pixel,
// so after the last sample of a frame send (width + 1) * components flush
// requests (cmd = 1) to drain the rest; the last of them carries frame_last.
// Flush requests before the frame is complete, and samples after it, give
// nothing. frame_start on a sample restarts the frame counters, and so does
// any register write. Write registers only while idle. Widths, heights and
// component counts outside their range are clamped.
module laplacian_edge_filter_3x3 #(
  parameter int MAX_WIDTH      = lef_pkg::MAX_WIDTH_DEF,
  parameter int MAX_COMPONENTS = lef_pkg::MAX_COMPONENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lef_in_if.sink                        in_ch,
  lef_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [lef_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lef_pkg::CFG_W-1:0]     cfg_data
);
  import lef_pkg::*;

  logic   q_push;
  logic   q_pop;
  qent_t  q_ent;
  qent_t  q_head;
  qstat_t q_stat;

  // Front: accept, track position, classify, read the line stores
  lef_front #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_ent    (q_ent)
  );

  // Short queue so the result side can stall briefly without stopping the front
  lef_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_ent  (q_ent),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  // Back: shift the window, compute and register the response
  lef_back #(
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  // The front only accepts when the queue has room for the request in flight
  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_stat.count < QCW'(QDEPTH)))
    else $error("queue written while full");

  a_q_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  // The frame always ends on a border pixel
  a_last_is_border: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_last) |-> (out_ch.filtered == '0))
    else $error("frame_last on a nonzero response");

endmodule
